FILE: src/smp_pkg.sv
package smp_pkg;

    // default coordinate width (signed fixed point)
    localparam int COORD_BITS_DEF = 16;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIRROR_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_START_X  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_START_Y  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_END_X    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_AXIS_END_Y    = 3'd4;

    // control travelling with each item; emit holds the mirror enable until
    // the range test, and the mirror decision after it
    typedef struct packed {
        logic valid;
        logic emit;
    } smp_ctl_t;

endpackage

FILE: src/smp_front.sv
module smp_front #(
    parameter int COORD_BITS = smp_pkg::COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic                          en,
    input  logic [COORD_BITS-1:0]         point_x,
    input  logic [COORD_BITS-1:0]         point_y,
    input  logic [COORD_BITS-1:0]         sx,
    input  logic [COORD_BITS-1:0]         sy,
    input  logic signed [COORD_BITS:0]    vx,
    input  logic signed [COORD_BITS:0]    vy,
    output smp_pkg::smp_ctl_t             ctl,
    output logic [COORD_BITS-1:0]         px,
    output logic [COORD_BITS-1:0]         py,
    output logic [3*COORD_BITS:0]         nx,
    output logic [3*COORD_BITS:0]         ny,
    output logic [2*COORD_BITS:0]         len
);
    import smp_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int PR_W  = 2*W + 2;   // signed product width
    localparam int LEN_W = 2*W + 1;   // |v|^2
    localparam int D_W   = 2*W + 3;   // dot product
    localparam int NUM_W = LEN_W + W; // d * |v|

    smp_ctl_t a_ctl_reg, a_ctl_next;
    smp_ctl_t b_ctl_reg, c_ctl_reg, d_ctl_reg, d_ctl_next;

    logic [W-1:0]         a_px_reg, a_py_reg, b_px_reg, b_py_reg;
    logic [W-1:0]         c_px_reg, c_py_reg, d_px_reg, d_py_reg;
    logic signed [W:0]    a_dx_reg, a_dy_reg;
    logic signed [PR_W-1:0] b_pdx_reg, b_pdy_reg, b_sqx_reg, b_sqy_reg;
    logic [D_W-1:0]       c_d_reg;
    logic [LEN_W-1:0]     c_len_reg, d_len_reg;
    logic [NUM_W-1:0]     d_nx_reg, d_ny_reg;
    logic [W-1:0]         abs_vx, abs_vy;
    logic [LEN_W-1:0]     d_lo;
    logic                 in_range;

    // magnitudes of the axis vector
    assign abs_vx = vx[W] ? W'(-vx) : W'(vx);
    assign abs_vy = vy[W] ? W'(-vy) : W'(vy);

    // stage A: capture and offset from segment start
    always_comb
    begin
        a_ctl_next.valid = in_valid;
        a_ctl_next.emit  = en;
    end

    // stage D: projection inside the segment and axis not degenerate
    assign in_range = (c_len_reg != '0) && !c_d_reg[D_W-1]
                      && ({2'b00, c_len_reg} >= c_d_reg);
    assign d_lo     = c_d_reg[LEN_W-1:0];

    always_comb
    begin
        d_ctl_next.valid = c_ctl_reg.valid;
        d_ctl_next.emit  = c_ctl_reg.emit && in_range;
    end

    // control, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
            d_ctl_reg <= '0;
        end
        else if (adv)
        begin
            a_ctl_reg <= a_ctl_next;
            b_ctl_reg <= a_ctl_reg;
            c_ctl_reg <= b_ctl_reg;
            d_ctl_reg <= d_ctl_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_px_reg  <= point_x;
            a_py_reg  <= point_y;
            a_dx_reg  <= $signed({point_x[W-1], point_x}) - $signed({sx[W-1], sx});
            a_dy_reg  <= $signed({point_y[W-1], point_y}) - $signed({sy[W-1], sy});
            // stage B: products
            b_px_reg  <= a_px_reg;
            b_py_reg  <= a_py_reg;
            b_pdx_reg <= a_dx_reg * vx;
            b_pdy_reg <= a_dy_reg * vy;
            b_sqx_reg <= vx * vx;
            b_sqy_reg <= vy * vy;
            // stage C: sums
            c_px_reg  <= b_px_reg;
            c_py_reg  <= b_py_reg;
            c_d_reg   <= {b_pdx_reg[PR_W-1], b_pdx_reg} + {b_pdy_reg[PR_W-1], b_pdy_reg};
            c_len_reg <= {1'b0, b_sqx_reg[2*W-1:0]} + {1'b0, b_sqy_reg[2*W-1:0]};
            // stage D: dividends
            d_px_reg  <= c_px_reg;
            d_py_reg  <= c_py_reg;
            d_len_reg <= c_len_reg;
            d_nx_reg  <= {{W{1'b0}}, d_lo} * {{LEN_W{1'b0}}, abs_vx};
            d_ny_reg  <= {{W{1'b0}}, d_lo} * {{LEN_W{1'b0}}, abs_vy};
        end
    end

    assign ctl = d_ctl_reg;
    assign px  = d_px_reg;
    assign py  = d_py_reg;
    assign nx  = d_nx_reg;
    assign ny  = d_ny_reg;
    assign len = d_len_reg;

endmodule

FILE: src/smp_divider.sv
module smp_divider #(
    parameter int COORD_BITS = smp_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  smp_pkg::smp_ctl_t     in_ctl,
    input  logic [COORD_BITS-1:0] in_px,
    input  logic [COORD_BITS-1:0] in_py,
    input  logic [3*COORD_BITS:0] in_nx,
    input  logic [3*COORD_BITS:0] in_ny,
    input  logic [2*COORD_BITS:0] in_len,
    output smp_pkg::smp_ctl_t     ctl,
    output logic [COORD_BITS-1:0] px,
    output logic [COORD_BITS-1:0] py,
    output logic [COORD_BITS-1:0] qx,
    output logic [COORD_BITS-1:0] qy
);
    import smp_pkg::*;

    localparam int W     = COORD_BITS;
    localparam int LEN_W = 2*W + 1;
    localparam int RL_W  = LEN_W + W;  // partial remainder over dividend/quotient bits

    // One restoring step. The upper LEN_W bits hold the partial remainder,
    // the lower W bits hold unused dividend bits shifting out while quotient
    // bits shift in. The dividend is below len * 2^W, so W steps suffice.
    function automatic logic [RL_W-1:0] div_step(input logic [RL_W-1:0] rl,
                                                  input logic [LEN_W-1:0] l);
        logic [LEN_W:0] t;
        logic [LEN_W:0] diff;
        logic           ge;
        t    = rl[RL_W-1:W-1];
        ge   = (t >= {1'b0, l});
        diff = t - {1'b0, l};
        if (ge)
            div_step = {diff[LEN_W-1:0], rl[W-2:0], 1'b1};
        else
            div_step = {t[LEN_W-1:0], rl[W-2:0], 1'b0};
    endfunction

    smp_ctl_t         ctl_reg [W];
    logic [RL_W-1:0]  rlx_reg [W];
    logic [RL_W-1:0]  rly_reg [W];
    logic [LEN_W-1:0] len_reg [W];
    logic [W-1:0]     px_reg  [W];
    logic [W-1:0]     py_reg  [W];

    smp_ctl_t         ctl_next [W];
    logic [RL_W-1:0]  rlx_next [W];
    logic [RL_W-1:0]  rly_next [W];
    logic [LEN_W-1:0] len_next [W];
    logic [W-1:0]     px_next  [W];
    logic [W-1:0]     py_next  [W];

    // one quotient bit per stage, x and y side by side
    always_comb
    begin
        for (int k = 0; k < W; k++)
        begin
            if (k == 0)
            begin
                ctl_next[k] = in_ctl;
                len_next[k] = in_len;
                px_next[k]  = in_px;
                py_next[k]  = in_py;
                rlx_next[k] = div_step(in_nx, in_len);
                rly_next[k] = div_step(in_ny, in_len);
            end
            else
            begin
                ctl_next[k] = ctl_reg[k-1];
                len_next[k] = len_reg[k-1];
                px_next[k]  = px_reg[k-1];
                py_next[k]  = py_reg[k-1];
                rlx_next[k] = div_step(rlx_reg[k-1], len_reg[k-1]);
                rly_next[k] = div_step(rly_reg[k-1], len_reg[k-1]);
            end
        end
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < W; k++)
                ctl_reg[k] <= '0;
        end
        else if (adv)
        begin
            for (int k = 0; k < W; k++)
                ctl_reg[k] <= ctl_next[k];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < W; k++)
            begin
                rlx_reg[k] <= rlx_next[k];
                rly_reg[k] <= rly_next[k];
                len_reg[k] <= len_next[k];
                px_reg[k]  <= px_next[k];
                py_reg[k]  <= py_next[k];
            end
        end
    end

    assign ctl = ctl_reg[W-1];
    assign px  = px_reg[W-1];
    assign py  = py_reg[W-1];
    assign qx  = rlx_reg[W-1][W-1:0];
    assign qy  = rly_reg[W-1][W-1:0];

endmodule

FILE: src/smp_output.sv
module smp_output #(
    parameter int COORD_BITS = smp_pkg::COORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smp_pkg::smp_ctl_t     in_ctl,
    input  logic [COORD_BITS-1:0] in_px,
    input  logic [COORD_BITS-1:0] in_py,
    input  logic [COORD_BITS-1:0] in_qx,
    input  logic [COORD_BITS-1:0] in_qy,
    input  logic [COORD_BITS-1:0] sx,
    input  logic [COORD_BITS-1:0] sy,
    input  logic                  neg_x,
    input  logic                  neg_y,
    output logic                  hold,
    output logic                  out_strobe,
    output logic [COORD_BITS-1:0] out_x,
    output logic [COORD_BITS-1:0] out_y,
    output logic                  is_mirrored,
    output logic                  last
);
    import smp_pkg::*;

    localparam int W   = COORD_BITS;
    localparam int R_W = W + 4;
    localparam logic [W-1:0] COORD_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] COORD_MIN = {1'b1, {(W-1){1'b0}}};

    smp_ctl_t     r_ctl_reg;
    logic [W-1:0] r_px_reg, r_py_reg, r_rx_reg, r_ry_reg;

    logic         pend_reg, pend_next;
    logic [W-1:0] pend_x_reg, pend_y_reg;
    logic         strobe_reg, strobe_next;
    logic         mir_reg, mir_next;
    logic         last_reg, last_next;
    logic [W-1:0] ox_reg, ox_next, oy_reg, oy_next;
    logic [W-1:0] rx_sat, ry_sat;
    logic         adv;

    // 2*(s +/- q) - p, clamped to the coordinate range
    function automatic logic [W-1:0] reflect(input logic [W-1:0] s,
                                             input logic [W-1:0] q,
                                             input logic         neg,
                                             input logic [W-1:0] p);
        logic [R_W-1:0] s_ext;
        logic [R_W-1:0] q_ext;
        logic [R_W-1:0] sum;
        logic [R_W-1:0] r;
        logic [4:0]     top;
        s_ext = {{4{s[W-1]}}, s};
        q_ext = {4'b0000, q};
        sum   = neg ? s_ext - q_ext : s_ext + q_ext;
        r     = {sum[R_W-2:0], 1'b0} - {{4{p[W-1]}}, p};
        top   = r[R_W-1:W-1];
        if ((&top) || !(|top))
            reflect = r[W-1:0];
        else if (r[R_W-1])
            reflect = COORD_MIN;
        else
            reflect = COORD_MAX;
    endfunction

    assign adv    = !pend_reg;
    assign rx_sat = reflect(sx, in_qx, neg_x, in_px);
    assign ry_sat = reflect(sy, in_qy, neg_y, in_py);

    // reflect stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            r_ctl_reg <= '0;
        else if (adv)
            r_ctl_reg <= in_ctl;
    end

    // reflect stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_px_reg <= in_px;
            r_py_reg <= in_py;
            r_rx_reg <= rx_sat;
            r_ry_reg <= ry_sat;
        end
    end

    // result sequencing: echo first, reflected point in the next cycle
    always_comb
    begin
        pend_next   = 1'b0;
        strobe_next = 1'b0;
        mir_next    = 1'b0;
        last_next   = 1'b0;
        ox_next     = r_px_reg;
        oy_next     = r_py_reg;
        if (pend_reg)
        begin
            strobe_next = 1'b1;
            mir_next    = 1'b1;
            last_next   = 1'b1;
            ox_next     = pend_x_reg;
            oy_next     = pend_y_reg;
        end
        else if (r_ctl_reg.valid)
        begin
            strobe_next = 1'b1;
            last_next   = !r_ctl_reg.emit;
            pend_next   = r_ctl_reg.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            pend_reg   <= pend_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mir_reg  <= mir_next;
        last_reg <= last_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        if (adv)
        begin
            pend_x_reg <= r_rx_reg;
            pend_y_reg <= r_ry_reg;
        end
    end

    assign hold        = pend_reg;
    assign out_strobe  = strobe_reg;
    assign out_x       = ox_reg;
    assign out_y       = oy_reg;
    assign is_mirrored = mir_reg;
    assign last        = last_reg;

endmodule

FILE: src/segment_mirror_point.sv
// The echoed point passes front stages A to D, the divider stages, the reflect
// stage and the output register; a reflected point follows in the next cycle.
// One point is taken per cycle while busy is low; busy stalls the pipe for a
// reflected point, since both results leave through the single result port.
// Reset (rst_n low, asynchronous) clears the configuration and the pipeline valids.
// The receiver cannot stall: each result is shown for exactly one cycle.
module segment_mirror_point #(
    parameter int COORD_BITS = smp_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [COORD_BITS-1:0]             point_x,
    input  logic [COORD_BITS-1:0]             point_y,
    output logic                              out_strobe,
    output logic [COORD_BITS-1:0]             out_x,
    output logic [COORD_BITS-1:0]             out_y,
    output logic                              is_mirrored,
    output logic                              last,
    input  logic                              cfg_write,
    input  logic [smp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data
);
    import smp_pkg::*;

    localparam int W = COORD_BITS;

    logic         mirror_enable_reg;
    logic [W-1:0] axis_start_x_reg, axis_start_y_reg;
    logic [W-1:0] axis_end_x_reg, axis_end_y_reg;

    logic signed [W:0] vx, vy;
    logic              hold, accept;

    smp_ctl_t          f_ctl, v_ctl;
    logic [W-1:0]      f_px, f_py, v_px, v_py, v_qx, v_qy;
    logic [3*W:0]      f_nx, f_ny;
    logic [2*W:0]      f_len;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_enable_reg <= 1'b0;
            axis_start_x_reg  <= '0;
            axis_start_y_reg  <= '0;
            axis_end_x_reg    <= '0;
            axis_end_y_reg    <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIRROR_ENABLE: mirror_enable_reg <= cfg_data[0];
                CFG_AXIS_START_X:  axis_start_x_reg  <= cfg_data;
                CFG_AXIS_START_Y:  axis_start_y_reg  <= cfg_data;
                CFG_AXIS_END_X:    axis_end_x_reg    <= cfg_data;
                CFG_AXIS_END_Y:    axis_end_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // axis vector; the user must keep configuration static while points are in flight; the block does not enforce this
    assign vx = $signed({axis_end_x_reg[W-1], axis_end_x_reg})
              - $signed({axis_start_x_reg[W-1], axis_start_x_reg});
    assign vy = $signed({axis_end_y_reg[W-1], axis_end_y_reg})
              - $signed({axis_start_y_reg[W-1], axis_start_y_reg});

    assign busy   = hold;
    assign accept = start && !hold;

    smp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (!hold),
        .in_valid (accept),
        .en       (mirror_enable_reg),
        .point_x  (point_x),
        .point_y  (point_y),
        .sx       (axis_start_x_reg),
        .sy       (axis_start_y_reg),
        .vx       (vx),
        .vy       (vy),
        .ctl      (f_ctl),
        .px       (f_px),
        .py       (f_py),
        .nx       (f_nx),
        .ny       (f_ny),
        .len      (f_len)
    );

    smp_divider #(.COORD_BITS(COORD_BITS)) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (!hold),
        .in_ctl (f_ctl),
        .in_px  (f_px),
        .in_py  (f_py),
        .in_nx  (f_nx),
        .in_ny  (f_ny),
        .in_len (f_len),
        .ctl    (v_ctl),
        .px     (v_px),
        .py     (v_py),
        .qx     (v_qx),
        .qy     (v_qy)
    );

    smp_output #(.COORD_BITS(COORD_BITS)) u_output (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ctl      (v_ctl),
        .in_px       (v_px),
        .in_py       (v_py),
        .in_qx       (v_qx),
        .in_qy       (v_qy),
        .sx          (axis_start_x_reg),
        .sy          (axis_start_y_reg),
        .neg_x       (vx[W]),
        .neg_y       (vy[W]),
        .hold        (hold),
        .out_strobe  (out_strobe),
        .out_x       (out_x),
        .out_y       (out_y),
        .is_mirrored (is_mirrored),
        .last        (last)
    );

    // while stalled, the echo of a mirrored point is on the ports
    a_busy_echo: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (out_strobe && !is_mirrored && !last))
        else $error("busy without a pending echo transfer");

    // a reflected point directly follows its non-final echo
    a_mirror_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && is_mirrored) |-> $past(out_strobe && !is_mirrored && !last))
        else $error("reflected point without preceding echo");

    // the reflected point always closes its run
    a_mirror_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_strobe && is_mirrored) |-> last)
        else $error("reflected point not marked last");

endmodule
